/* rtl/w5tm_pkg.sv */
// shared types and constants of the five-sample trimmed-mean filter
package w5tm_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int NUM_CELLS   = 5;
	localparam int KEEP_COUNT  = 3;
	// sum of five samples needs three extra bits
	localparam int SUM_W       = 19;
	// sum of the middle three fits in 18 bits
	localparam int TRIM_W      = 18;
	// floor(x / 3) = (x * ceil(2^19 / 3)) >> 19, exact for x < 2^19
	localparam int RECIP_SHIFT = 19;
	localparam logic [TRIM_W-1:0] RECIP_3 = 18'd174763;
	localparam int PROD_W      = 2 * TRIM_W;

	// running reduction handed from cell to cell
	typedef struct packed {
		logic [SUM_W-1:0]    sum;
		logic [SAMPLE_W-1:0] min;
		logic [SAMPLE_W-1:0] max;
	} acc_t;

endpackage

/* rtl/w5tm_sample_if.sv */
// input channel carrying one sample per item
interface w5tm_sample_if;
	logic                           valid;
	logic                           ready;
	logic [w5tm_pkg::SAMPLE_W-1:0]  sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

/* rtl/w5tm_filtered_if.sv */
// output channel carrying one filtered value per item
interface w5tm_filtered_if;
	logic                           valid;
	logic                           ready;
	logic [w5tm_pkg::SAMPLE_W-1:0]  filtered;

	modport source (output valid, output filtered, input ready);
	modport sink (input valid, input filtered, output ready);
endinterface

/* rtl/w5tm_cell.sv */
// one window cell: holds a sample, shifts it on, folds the new value into the running reduction
module w5tm_cell #(
	parameter logic [w5tm_pkg::SAMPLE_W-1:0] FILL = 16'd159
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          shift,
	input  logic [w5tm_pkg::SAMPLE_W-1:0] d,
	input  w5tm_pkg::acc_t                acc_in,
	output logic [w5tm_pkg::SAMPLE_W-1:0] q,
	output w5tm_pkg::acc_t                acc_out
);

	logic [w5tm_pkg::SAMPLE_W-1:0] value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= FILL;
		end else if (shift) begin
			value_q <= d;
		end
	end

	assign q = value_q;

	// d is this cell's value once the shift has happened
	always_comb begin
		acc_out.sum = acc_in.sum + w5tm_pkg::SUM_W'(d);
		acc_out.min = (d < acc_in.min) ? d : acc_in.min;
		acc_out.max = (d > acc_in.max) ? d : acc_in.max;
	end

endmodule

/* rtl/window5_trimmed_mean_filter.sv */
// top level of the five-sample trimmed-mean filter
// Five-sample trimmed-mean filter. Every accepted sample shifts into a row of
// five cells (newest first); the cells start out holding FILL_VALUE, which
// takes part in the result like a real sample until it is shifted out. For
// each item the block drops one smallest and one largest of the five window
// values and returns floor(sum of the other three / 3). One item is accepted
// per clock while ready is high, and each item yields exactly one result:
// the cell chain forms sum, minimum and maximum in the accept cycle and
// registers the trimmed sum, then a reciprocal multiply by one third loads
// the output register. Throughput is one item per cycle while ready is high,
// set by the single cell chain; a waiting result does not block input while
// the middle stage is free, and ready falls only when both stages hold items
// and the output is not being taken.
module window5_trimmed_mean_filter #(
	parameter int FILL_VALUE = 159
) (
	input  logic                    clk,
	input  logic                    arst_n,
	w5tm_sample_if.sink             samples,
	w5tm_filtered_if.source         results
);

	localparam logic [w5tm_pkg::SAMPLE_W-1:0] FILL = w5tm_pkg::SAMPLE_W'(FILL_VALUE);

	// handshake and stage control
	logic accept;
	logic adv_out;
	logic valid_s1;
	logic out_valid_q;

	// cell chain
	logic [w5tm_pkg::SAMPLE_W-1:0] cell_d [w5tm_pkg::NUM_CELLS];
	logic [w5tm_pkg::SAMPLE_W-1:0] cell_q [w5tm_pkg::NUM_CELLS];
	w5tm_pkg::acc_t                acc [w5tm_pkg::NUM_CELLS+1];

	// datapath
	logic [w5tm_pkg::SUM_W-1:0]    trim_full;
	logic [w5tm_pkg::TRIM_W-1:0]   trim_sum_s1;
	logic [w5tm_pkg::PROD_W-1:0]   prod;
	logic [w5tm_pkg::SAMPLE_W-1:0] filtered_q;

	// output register frees when empty or being taken; stage 1 frees when
	// empty or moving into the output register
	assign adv_out       = !out_valid_q || results.ready;
	assign samples.ready = !valid_s1 || adv_out;
	assign accept        = samples.valid && samples.ready;

	// reduction starts empty: zero sum, max-ranged minimum, zero maximum
	assign acc[0].sum = '0;
	assign acc[0].min = '1;
	assign acc[0].max = '0;

	// cell 0 takes the new sample, each later cell takes its left neighbor
	assign cell_d[0] = samples.sample;

	genvar k;
	generate
		for (k = 1; k < w5tm_pkg::NUM_CELLS; k++) begin : g_link
			assign cell_d[k] = cell_q[k-1];
		end
		for (k = 0; k < w5tm_pkg::NUM_CELLS; k++) begin : g_cell
			w5tm_cell #(
				.FILL (FILL)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.shift   (accept),
				.d       (cell_d[k]),
				.acc_in  (acc[k]),
				.q       (cell_q[k]),
				.acc_out (acc[k+1])
			);
		end
	endgenerate

	// drop one minimum and one maximum; the rest always fits in 18 bits
	assign trim_full = acc[w5tm_pkg::NUM_CELLS].sum
		- w5tm_pkg::SUM_W'(acc[w5tm_pkg::NUM_CELLS].min)
		- w5tm_pkg::SUM_W'(acc[w5tm_pkg::NUM_CELLS].max);

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			trim_sum_s1 <= trim_full[w5tm_pkg::TRIM_W-1:0];
		end
	end

	// divide by three through the reciprocal
	assign prod = w5tm_pkg::PROD_W'(trim_sum_s1) * w5tm_pkg::PROD_W'(w5tm_pkg::RECIP_3);

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_out) begin
			out_valid_q <= valid_s1;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (adv_out && valid_s1) begin
			filtered_q <= prod[w5tm_pkg::RECIP_SHIFT +: w5tm_pkg::SAMPLE_W];
		end
	end

	assign results.valid    = out_valid_q;
	assign results.filtered = filtered_q;

`ifndef ASSERT_OFF
	logic [w5tm_pkg::TRIM_W-1:0] back3;
	assign back3 = w5tm_pkg::TRIM_W'(results.filtered) * w5tm_pkg::TRIM_W'(w5tm_pkg::KEEP_COUNT);

	// input stalls only when both stages are occupied
	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!samples.ready |-> (valid_s1 && out_valid_q))
		else $error("input stalled with a free stage");

	// an accepted item reaches stage 1 on the next edge
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted item lost before stage 1");

	// a stage 1 item that cannot move keeps its place
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_out) |=> (valid_s1 && $stable(trim_sum_s1)))
		else $error("stage 1 item dropped or changed while stalled");

	// the chain's minimum never exceeds its maximum
	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (acc[w5tm_pkg::NUM_CELLS].min <= acc[w5tm_pkg::NUM_CELLS].max))
		else $error("window minimum above maximum");

	// loaded result is the exact floor of the trimmed sum over three
	a_div3_exact: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_out && valid_s1) |=> ((back3 <= $past(trim_sum_s1))
			&& (($past(trim_sum_s1) - back3) < w5tm_pkg::TRIM_W'(w5tm_pkg::KEEP_COUNT))))
		else $error("division by three is off");
`endif

endmodule

/* verif/trimmed_mean_checker.sv */
`timescale 1ns / 100ps
// checker of the trimmed-mean filter: predicts each filtered value and compares it
module trimmed_mean_checker #(
	parameter int FILL_VALUE = 159
) (
	input  logic      clk,
	input  logic      arst_n,
	w5tm_sample_if    samples,
	w5tm_filtered_if  results,
	output int        failures,
	output int        pending
);

	localparam int REPORT_LIMIT = 10;

	// newest sample in slot 0, oldest in the last slot
	logic [w5tm_pkg::SAMPLE_W-1:0] history [w5tm_pkg::NUM_CELLS];
	logic [w5tm_pkg::SAMPLE_W-1:0] expected_means [$];
	int                            accepted_results;

	// drop one lowest and one highest, floor of the mean of the other three
	function automatic logic [w5tm_pkg::SAMPLE_W-1:0] middle_mean();
		logic [w5tm_pkg::SUM_W-1:0]    total;
		logic [w5tm_pkg::SAMPLE_W-1:0] lo;
		logic [w5tm_pkg::SAMPLE_W-1:0] hi;
		total = '0;
		lo = history[0];
		hi = history[0];
		for (int k = 0; k < w5tm_pkg::NUM_CELLS; k++) begin
			total = total + w5tm_pkg::SUM_W'(history[k]);
			if (history[k] < lo)
				lo = history[k];
			if (history[k] > hi)
				hi = history[k];
		end
		total = total - w5tm_pkg::SUM_W'(lo) - w5tm_pkg::SUM_W'(hi);
		return w5tm_pkg::SAMPLE_W'(total / w5tm_pkg::KEEP_COUNT);
	endfunction

	initial begin
		failures = 0;
		pending = 0;
		accepted_results = 0;
	end

	// sampled mid-cycle: a handshake seen here completes at the next rising edge
	always @(negedge clk) begin
		logic [w5tm_pkg::SAMPLE_W-1:0] got;
		logic [w5tm_pkg::SAMPLE_W-1:0] want;
		if (!arst_n) begin
			foreach (history[k])
				history[k] = w5tm_pkg::SAMPLE_W'(FILL_VALUE);
			expected_means.delete();
		end else begin
			if (samples.valid && samples.ready) begin
				for (int k = w5tm_pkg::NUM_CELLS - 1; k > 0; k--)
					history[k] = history[k-1];
				history[0] = samples.sample;
				expected_means.push_back(middle_mean());
			end
			if (results.valid && results.ready) begin
				got = results.filtered;
				accepted_results++;
				if (expected_means.size() == 0) begin
					failures++;
					if (failures <= REPORT_LIMIT)
						$display("result item %0d: filtered %0d arrived with nothing pending",
							accepted_results, got);
				end else begin
					want = expected_means.pop_front();
					if (got !== want) begin
						failures++;
						if (failures <= REPORT_LIMIT)
							$display("result item %0d: filtered expected %0d, got %0d",
								accepted_results, want, got);
					end
				end
			end
		end
		pending = expected_means.size();
	end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps
// top of the trimmed-mean filter testbench: clock, reset, stimulus and verdict
module testbench;

	localparam int FILL_VALUE    = 159;
	localparam int RANDOM_ITEMS  = 1950;
	// tail of the random part that runs with no idling on either side
	localparam int CALM_ITEMS    = 250;
	// cycles with no handshake on either channel before the run is called hung;
	// a correct run never idles longer than a sender gap plus a sink stall plus
	// the pass through stage 1 and the output register
	localparam int IDLE_LIMIT    = 1000;
	// extra cycles after the last expected item, enough to catch a stray result
	localparam int SETTLE_CYCLES = 8;

	// random flavors of sample runs
	localparam int FLAVOR_UNIFORM  = 0;
	localparam int FLAVOR_TRACK    = 1;
	localparam int FLAVOR_EXTREME  = 2;
	localparam int FLAVOR_REPEAT   = 3;
	localparam int FLAVOR_NEARFILL = 4;

	logic clk = 1'b0;
	logic arst_n;
	int   failures;
	int   pending;

	// idling rates in percent, changed from run to run by the stimulus
	int   send_gap_pct;
	int   sink_stall_pct;

	logic [w5tm_pkg::SAMPLE_W-1:0] track_pos;
	logic [w5tm_pkg::SAMPLE_W-1:0] last_sample;

	// directed opening: the first items still see fill values in the window,
	// then full-scale values, all zeros, values around the fill value,
	// alternating bit patterns and ramps with ties and near-ties
	logic [w5tm_pkg::SAMPLE_W-1:0] directed_samples [22] = '{
		16'd0,     16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
		16'd0,     16'd0,    16'd0,    16'd0,    16'd0,
		16'd159,   16'd160,  16'd158,
		16'hAAAA,  16'h5555, 16'hAAAA,
		16'd1,     16'd2,    16'd3,    16'd65534, 16'd4
	};

	w5tm_sample_if   samples ();
	w5tm_filtered_if results ();

	window5_trimmed_mean_filter #(
		.FILL_VALUE (FILL_VALUE)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples),
		.results (results)
	);

	trimmed_mean_checker #(
		.FILL_VALUE (FILL_VALUE)
	) i_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.samples  (samples),
		.results  (results),
		.failures (failures),
		.pending  (pending)
	);

	always #5ns clk = ~clk;

	// hand one sample to the filter; returns at the rising edge that takes it.
	// valid stays high on return so back-to-back items need no second write
	task automatic push_sample(input logic [w5tm_pkg::SAMPLE_W-1:0] value);
		if (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
			samples.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		samples.valid  <= 1'b1;
		samples.sample <= value;
		// ready is settled mid-cycle, so the next edge takes the item
		do @(negedge clk); while (!samples.ready);
		@(posedge clk);
		last_sample = value;
	endtask

	// hold the sender off until every predicted value has come back
	task automatic wait_drained();
		samples.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// one sample of the given flavor
	function automatic logic [w5tm_pkg::SAMPLE_W-1:0] pick_sample(input int flavor);
		int step;
		case (flavor)
			FLAVOR_TRACK: begin
				// a slowly drifting coordinate with an occasional outlier,
				// which is what the filter is meant to suppress
				step = int'(track_pos) + $urandom_range(0, 64) - 32;
				if (step < 0)
					step = 0;
				if (step > 65535)
					step = 65535;
				track_pos = w5tm_pkg::SAMPLE_W'(step);
				if ($urandom_range(7) == 0)
					return w5tm_pkg::SAMPLE_W'($urandom());
				return track_pos;
			end
			FLAVOR_EXTREME: begin
				case ($urandom_range(4))
					0: return '0;
					1: return '1;
					2: return w5tm_pkg::SAMPLE_W'(FILL_VALUE);
					3: return w5tm_pkg::SAMPLE_W'(1);
					default: return w5tm_pkg::SAMPLE_W'(65534);
				endcase
			end
			// ties: the same value again
			FLAVOR_REPEAT:   return last_sample;
			FLAVOR_NEARFILL: return w5tm_pkg::SAMPLE_W'($urandom_range(0, 2 * FILL_VALUE));
			default:         return w5tm_pkg::SAMPLE_W'($urandom());
		endcase
	endfunction

	// result side: ready drops in random bursts at the current stall rate
	initial begin : sink_side
		results.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (sink_stall_pct > 0 && $urandom_range(99) < sink_stall_pct) begin
				results.ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
			results.ready <= 1'b1;
		end
	end

	// ends the run if neither channel moves for too long
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(negedge clk);
			if ((samples.valid && samples.ready) || (results.valid && results.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin : stimulus
		int sent;
		int run_len;
		int flavor;
		arst_n         <= 1'b0;
		samples.valid  <= 1'b0;
		samples.sample <= '0;
		send_gap_pct   = 0;
		sink_stall_pct = 0;
		track_pos      = w5tm_pkg::SAMPLE_W'(FILL_VALUE);
		last_sample    = '0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at full rate, right after reset
		foreach (directed_samples[i])
			push_sample(directed_samples[i]);
		// the sender waits here until every result is back
		wait_drained();

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			// idling rates change now and then; the tail runs with none
			if (RANDOM_ITEMS - sent <= CALM_ITEMS) begin
				send_gap_pct   = 0;
				sink_stall_pct = 0;
			end else if ($urandom_range(7) == 0) begin
				case ($urandom_range(4))
					0, 1: send_gap_pct = 0;
					2:    send_gap_pct = 5;
					3:    send_gap_pct = 20;
					default: send_gap_pct = 50;
				endcase
				case ($urandom_range(4))
					0, 1: sink_stall_pct = 0;
					2:    sink_stall_pct = 5;
					3:    sink_stall_pct = 20;
					default: sink_stall_pct = 50;
				endcase
			end
			// now and then the pipeline is left to empty completely
			if (RANDOM_ITEMS - sent > CALM_ITEMS && $urandom_range(39) == 0)
				wait_drained();
			flavor  = $urandom_range(FLAVOR_UNIFORM, FLAVOR_NEARFILL);
			run_len = $urandom_range(3, 20);
			if (run_len > RANDOM_ITEMS - sent)
				run_len = RANDOM_ITEMS - sent;
			repeat (run_len)
				push_sample(pick_sample(flavor));
			sent += run_len;
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

/* filelist.f */
rtl/w5tm_pkg.sv
rtl/w5tm_sample_if.sv
rtl/w5tm_filtered_if.sv
rtl/w5tm_cell.sv
rtl/window5_trimmed_mean_filter.sv
verif/trimmed_mean_checker.sv
verif/testbench.sv
